// ===== rtl/swkrc_pkg.sv =====
// ----------------------------------------------------------------------------
// swkrc_pkg
// Shared types and constants for the sliding-window key press rate counter.
// ----------------------------------------------------------------------------
package swkrc_pkg;

  localparam int DEF_RING_DEPTH = 1024;
  localparam int DEF_KEY_COUNT  = 256;

  localparam int CMD_W      = 2;
  localparam int KEY_CODE_W = 8;
  localparam int WINDOW_W   = 16;
  localparam int OUT_W      = 11;
  localparam int STAMP_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WINDOW_W-1:0] DEF_WINDOW_TICKS = WINDOW_W'(1000);
  localparam logic [OUT_W-1:0]    DEF_DISPLAY_CAP  = OUT_W'(100);

  // item commands
  localparam logic [CMD_W-1:0] CMD_KEY_DOWN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_KEY_UP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_CAP  = 1'd1;

  typedef struct packed {
    logic load;
    logic clear;
    logic key_update;
    logic tick;
    logic pop;
    logic result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic expire_hit;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/swkrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// swkrc_ctrl
// Sequencer: key table clear pass, item decode, expiry loop and result hand-off.
// ----------------------------------------------------------------------------
module swkrc_ctrl import swkrc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] command,
  input  dp_status_t       st,
  output ctrl_cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_KEY    = 6'b000100,
    S_TICK   = 6'b001000,
    S_EXPIRE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (command)
            CMD_KEY_DOWN, CMD_KEY_UP: state_next = S_KEY;
            CMD_TICK:                 state_next = S_TICK;
            default:                  state_next = S_DONE;
          endcase
        end
      end
      S_KEY: begin
        cmd.key_update = 1'b1;
        state_next     = S_DONE;
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = S_EXPIRE;
      end
      S_EXPIRE: begin
        if (st.expire_hit) begin
          cmd.pop = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/swkrc_datapath.sv =====
// ----------------------------------------------------------------------------
// swkrc_datapath
// Key held table, stamp ring memory, tick counter, config and output register.
// ----------------------------------------------------------------------------
module swkrc_datapath import swkrc_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int KEY_COUNT  = DEF_KEY_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            st,
  input  logic [CMD_W-1:0]      command,
  input  logic [KEY_CODE_W-1:0] key_code,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      window_count,
  output logic [OUT_W-1:0]      display_count,
  output logic                  at_cap,
  output logic                  press_counted
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  logic                 key_mem [KEY_COUNT];
  logic [STAMP_W-1:0]   stamp_ring [RING_DEPTH];

  logic [CMD_W-1:0]     cmd_q;
  logic [KEY_W-1:0]     key_q;
  logic                 key_ok_q;
  logic                 key_rd;
  logic                 counted;
  logic [KEY_W-1:0]     clear_idx;
  logic [STAMP_W-1:0]   now_ticks;
  logic [PTR_W-1:0]     ring_head;
  logic [PTR_W-1:0]     ring_tail;
  logic [CNT_W-1:0]     pending_count;
  logic [STAMP_W-1:0]   stamp_rd;
  logic [WINDOW_W-1:0]  window_ticks;
  logic [OUT_W-1:0]     display_cap;

  logic [31:0]          key_ext;
  logic [KEY_W-1:0]     key_idx_in;
  logic                 ring_full;
  logic                 do_push;
  logic                 key_wr;
  logic [PTR_W-1:0]     head_next;
  logic [STAMP_W-1:0]   age;
  logic [31:0]          pend_ext;
  logic [31:0]          cap_ext;
  logic                 below_cap;
  logic [31:0]          shown;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign key_ext    = 32'(key_code);
  assign key_idx_in = key_ext[KEY_W-1:0];
  assign ring_full  = (pending_count == CNT_W'(RING_DEPTH));
  assign do_push    = cmd.key_update && key_ok_q && (cmd_q == CMD_KEY_DOWN) && !key_rd;
  assign key_wr     = cmd.key_update && key_ok_q &&
                      (((cmd_q == CMD_KEY_DOWN) && !key_rd) || (cmd_q == CMD_KEY_UP));
  assign head_next  = ((do_push && ring_full) || cmd.pop) ? ring_next(ring_head) : ring_head;
  assign age        = now_ticks - stamp_rd;

  assign st.clear_last = (clear_idx == KEY_W'(KEY_COUNT - 1));
  assign st.expire_hit = (pending_count != '0) && (age > STAMP_W'(window_ticks));
  assign st.out_free   = !out_valid || out_ready;

  assign pend_ext  = 32'(pending_count);
  assign cap_ext   = 32'(display_cap);
  assign below_cap = (pend_ext < cap_ext);
  assign shown     = below_cap ? pend_ext : cap_ext;

  // key held table
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      key_mem[clear_idx] <= 1'b0;
    end else if (key_wr) begin
      key_mem[key_q] <= (cmd_q == CMD_KEY_DOWN);
    end
    key_rd <= key_mem[key_idx_in];
  end

  // stamp ring
  always_ff @(posedge clk) begin
    if (do_push) begin
      stamp_ring[ring_tail] <= now_ticks;
    end
    stamp_rd <= stamp_ring[head_next];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q    <= command;
      key_q    <= key_idx_in;
      key_ok_q <= (key_ext < 32'(KEY_COUNT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx     <= '0;
      counted       <= 1'b0;
      now_ticks     <= '0;
      ring_head     <= '0;
      ring_tail     <= '0;
      pending_count <= '0;
    end else begin
      if (cmd.clear) begin
        clear_idx <= clear_idx + KEY_W'(1);
      end
      if (cmd.load) begin
        counted <= 1'b0;
      end else if (do_push) begin
        counted <= 1'b1;
      end
      if (cmd.tick) begin
        now_ticks <= now_ticks + STAMP_W'(1);
      end
      ring_head <= head_next;
      if (do_push) begin
        ring_tail <= ring_next(ring_tail);
        if (!ring_full) begin
          pending_count <= pending_count + CNT_W'(1);
        end
      end else if (cmd.pop) begin
        pending_count <= pending_count - CNT_W'(1);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= DEF_WINDOW_TICKS;
      display_cap  <= DEF_DISPLAY_CAP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_TICKS: window_ticks <= cfg_data;
        REG_DISPLAY_CAP:  display_cap  <= cfg_data[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      window_count  <= pend_ext[OUT_W-1:0];
      display_count <= shown[OUT_W-1:0];
      at_cap        <= !below_cap;
      press_counted <= counted;
    end
  end

endmodule

// ===== rtl/sliding_window_keypress_rate_counter.sv =====
// ----------------------------------------------------------------------------
// sliding_window_keypress_rate_counter
// Counts key presses whose stamps lie inside a sliding window of ticks.
// ----------------------------------------------------------------------------
// One item at a time. A key-down or key-up passes through the key update and
// done states to its result, and the next item is taken after that; a tick
// passes through the tick, expiry and done states, popping expired stamps one
// per cycle from the single read port of the stamp ring memory; an unused
// command goes straight to the done state. After reset the key held table is
// cleared one entry per cycle, so no item is accepted until every entry is
// cleared; configuration writes are taken at any time and complete at once.
// A result waits in the output register while the next item is accepted.
module sliding_window_keypress_rate_counter import swkrc_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH,
  parameter int KEY_COUNT  = DEF_KEY_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      command,
  input  logic [KEY_CODE_W-1:0] key_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      window_count,
  output logic [OUT_W-1:0]      display_count,
  output logic                  at_cap,
  output logic                  press_counted,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  swkrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .st       (st),
    .cmd      (cmd)
  );

  swkrc_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .KEY_COUNT  (KEY_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .command       (command),
    .key_code      (key_code),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .window_count  (window_count),
    .display_count (display_count),
    .at_cap        (at_cap),
    .press_counted (press_counted)
  );

`ifndef NO_ASSERTIONS
  // one item in flight: no new transaction right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // below the cap the shown count is the window count itself
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !at_cap |-> display_count == window_count)
    else $error("display count differs from window count below cap");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk) disable iff (rst)
    cmd.result |-> !out_valid || out_ready)
    else $error("result loaded over a pending transaction");
`endif

endmodule
